// ===== design/afk_pkg.sv =====
// Shared constants and tables for the arm segment forward kinematics block.
package afk_pkg;

    localparam int ANGLE_W       = 16;
    localparam int OUT_W         = 15;
    localparam int AW            = 24;
    localparam int CW            = 19;
    localparam int CORDIC_STEPS  = 16;
    localparam int SC_LAT        = 23;
    localparam int KIN_LAT       = 11;
    localparam int CFG_IDX_W     = 2;
    localparam int OUT_MAX       = 12285;

    localparam logic [CFG_IDX_W-1:0] REG_LEN_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEN_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LEN_Z = 2'd2;

    localparam logic signed [AW-1:0] Q16_PI      = 24'sd205887;
    localparam logic signed [AW-1:0] Q16_TWO_PI  = 24'sd411775;
    localparam logic signed [AW-1:0] Q16_HALF_PI = 24'sd102944;
    localparam logic [AW-1:0] Q16_TWO_PI_U  = 24'd411775;
    localparam logic [AW-1:0] Q16_FOUR_PI_U = 24'd823550;
    localparam logic [AW-1:0] Q16_EIGHT_PI_U = 24'd1647100;
    localparam logic signed [CW-1:0] CORDIC_GAIN = 19'sd39797;

    localparam logic signed [AW-1:0] ATAN_Q16 [CORDIC_STEPS] = '{
        24'sd51472, 24'sd30386, 24'sd16055, 24'sd8150,
        24'sd4091,  24'sd2047,  24'sd1024,  24'sd512,
        24'sd256,   24'sd128,   24'sd64,    24'sd32,
        24'sd16,    24'sd8,     24'sd4,     24'sd2
    };

endpackage

// ===== design/afk_if.sv =====
// Valid/ready channels carrying the pose word and the tip position word.
interface afk_pose_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] local_pitch;
    logic signed [15:0] local_yaw;
    logic signed [15:0] frame_roll;
    logic signed [15:0] frame_pitch;
    logic signed [15:0] frame_yaw;

    modport source (output valid, local_pitch, local_yaw, frame_roll, frame_pitch,
                    frame_yaw, input ready);
    modport sink (input valid, local_pitch, local_yaw, frame_roll, frame_pitch,
                  frame_yaw, output ready);
endinterface

interface afk_pos_if;
    logic               valid;
    logic               ready;
    logic signed [14:0] pos_x;
    logic signed [14:0] pos_y;
    logic signed [14:0] pos_z;

    modport source (output valid, pos_x, pos_y, pos_z, input ready);
    modport sink (input valid, pos_x, pos_y, pos_z, output ready);
endinterface

// ===== design/afk_sincos.sv =====
// Pipelined angle reduction and 16-stage rotation CORDIC giving sin and cos in Q16.
module afk_sincos
    import afk_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = 13
)
(
    input  logic                      clk,
    input  logic                      en,
    input  logic signed [ANGLE_W-1:0] angle,
    output logic signed [CW-1:0]      sin_q,
    output logic signed [CW-1:0]      cos_q
);

    localparam int LSH = (ANGLE_FRAC_BITS <= 16) ? 16 - ANGLE_FRAC_BITS : 0;
    localparam int RSH = (ANGLE_FRAC_BITS > 16) ? ANGLE_FRAC_BITS - 16 : 1;

    logic signed [AW-1:0] q16;
    logic [AW-1:0]        mag;
    logic [AW-1:0]        mag0_reg, m1_reg, m2_reg;
    logic [AW-1:0]        m3;
    logic [2:0]           neg_reg;
    logic signed [AW-1:0] t3_reg, t4_reg;
    logic signed [AW-1:0] t4_next;
    logic signed [CW-1:0] cx_reg [CORDIC_STEPS+1];
    logic signed [CW-1:0] cy_reg [CORDIC_STEPS+1];
    logic signed [AW-1:0] ct_reg [CORDIC_STEPS+1];
    logic                 cf_reg [CORDIC_STEPS+1];
    logic signed [CW-1:0] sin_reg, cos_reg;

    generate
        if (ANGLE_FRAC_BITS <= 16)
        begin : g_left
            assign q16 = AW'(angle) <<< LSH;
        end
        else
        begin : g_right
            assign q16 = (AW'(angle) + signed'(AW'(1 << (RSH - 1)))) >>> RSH;
        end
    endgenerate

    assign mag = q16[AW-1] ? AW'(-q16) : AW'(q16);
    assign m3  = (m2_reg >= Q16_TWO_PI_U) ? m2_reg - Q16_TWO_PI_U : m2_reg;

    always_comb
    begin
        if (t3_reg > Q16_PI)
            t4_next = t3_reg - Q16_TWO_PI;
        else if (t3_reg < -Q16_PI)
            t4_next = t3_reg + Q16_TWO_PI;
        else
            t4_next = t3_reg;
    end

    // truncating remainder by 2*pi in three restoring steps
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag0_reg   <= mag;
            neg_reg[0] <= q16[AW-1];
            m1_reg     <= (mag0_reg >= Q16_EIGHT_PI_U) ? mag0_reg - Q16_EIGHT_PI_U : mag0_reg;
            neg_reg[1] <= neg_reg[0];
            m2_reg     <= (m1_reg >= Q16_FOUR_PI_U) ? m1_reg - Q16_FOUR_PI_U : m1_reg;
            neg_reg[2] <= neg_reg[1];
            t3_reg     <= neg_reg[2] ? -signed'(m3) : signed'(m3);
            t4_reg     <= t4_next;
            cx_reg[0]  <= CORDIC_GAIN;
            cy_reg[0]  <= '0;
            if (t4_reg > Q16_HALF_PI)
            begin
                ct_reg[0] <= t4_reg - Q16_PI;
                cf_reg[0] <= 1'b1;
            end
            else if (t4_reg < -Q16_HALF_PI)
            begin
                ct_reg[0] <= t4_reg + Q16_PI;
                cf_reg[0] <= 1'b1;
            end
            else
            begin
                ct_reg[0] <= t4_reg;
                cf_reg[0] <= 1'b0;
            end
            sin_reg <= cf_reg[CORDIC_STEPS] ? -cy_reg[CORDIC_STEPS] : cy_reg[CORDIC_STEPS];
            cos_reg <= cf_reg[CORDIC_STEPS] ? -cx_reg[CORDIC_STEPS] : cx_reg[CORDIC_STEPS];
        end
    end

    generate
        for (genvar i = 0; i < CORDIC_STEPS; i++)
        begin : g_step
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    cf_reg[i+1] <= cf_reg[i];
                    if (ct_reg[i] >= 0)
                    begin
                        cx_reg[i+1] <= cx_reg[i] - (cy_reg[i] >>> i);
                        cy_reg[i+1] <= cy_reg[i] + (cx_reg[i] >>> i);
                        ct_reg[i+1] <= ct_reg[i] - ATAN_Q16[i];
                    end
                    else
                    begin
                        cx_reg[i+1] <= cx_reg[i] + (cy_reg[i] >>> i);
                        cy_reg[i+1] <= cy_reg[i] - (cx_reg[i] >>> i);
                        ct_reg[i+1] <= ct_reg[i] + ATAN_Q16[i];
                    end
                end
            end
        end
    endgenerate

    assign sin_q = sin_reg;
    assign cos_q = cos_reg;

endmodule

// ===== design/afk_rot.sv =====
// Two-stage plane rotation: floor((a*c - b*s)/2^16) and floor((a*s + b*c)/2^16).
module afk_rot
    import afk_pkg::*;
#(
    parameter int PW = 32
)
(
    input  logic                 clk,
    input  logic                 en,
    input  logic signed [PW-1:0] a,
    input  logic signed [PW-1:0] b,
    input  logic signed [CW-1:0] c,
    input  logic signed [CW-1:0] s,
    output logic signed [PW-1:0] o1,
    output logic signed [PW-1:0] o2
);

    localparam int HW  = PW - 16;
    localparam int HPW = HW + CW;
    localparam int LPW = 17 + CW;

    logic signed [HW-1:0]  a_hi, b_hi;
    logic signed [16:0]    a_lo, b_lo;
    logic signed [HPW-1:0] ach_reg, bsh_reg, ash_reg, bch_reg;
    logic signed [LPW-1:0] acl_reg, bsl_reg, asl_reg, bcl_reg;
    logic signed [HPW:0]   hi1, hi2;
    logic signed [LPW:0]   lo1, lo2;
    logic signed [HPW+1:0] sum1, sum2;
    logic signed [PW-1:0]  o1_reg, o2_reg;

    // split operands into signed high part and unsigned low 16 bits
    assign a_hi = a[PW-1:16];
    assign b_hi = b[PW-1:16];
    assign a_lo = signed'({1'b0, a[15:0]});
    assign b_lo = signed'({1'b0, b[15:0]});

    assign hi1  = (HPW+1)'(ach_reg) - (HPW+1)'(bsh_reg);
    assign hi2  = (HPW+1)'(ash_reg) + (HPW+1)'(bch_reg);
    assign lo1  = (LPW+1)'(acl_reg) - (LPW+1)'(bsl_reg);
    assign lo2  = (LPW+1)'(asl_reg) + (LPW+1)'(bcl_reg);
    assign sum1 = (HPW+2)'(hi1) + (HPW+2)'(lo1 >>> 16);
    assign sum2 = (HPW+2)'(hi2) + (HPW+2)'(lo2 >>> 16);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ach_reg <= a_hi * c;
            bsh_reg <= b_hi * s;
            ash_reg <= a_hi * s;
            bch_reg <= b_hi * c;
            acl_reg <= a_lo * c;
            bsl_reg <= b_lo * s;
            asl_reg <= a_lo * s;
            bcl_reg <= b_lo * c;
            o1_reg  <= PW'(sum1);
            o2_reg  <= PW'(sum2);
        end
    end

    assign o1 = o1_reg;
    assign o2 = o2_reg;

endmodule

// ===== design/arm_segment_forward_kinematics.sv =====
// Forward kinematics of one arm segment: joint and frame angles in, tip position out.
// Fully pipelined: a pose word is taken every cycle while the output is not stalled,
// and passes through angle reduction and CORDIC, then projection, four chained plane
// rotations and rounding. All stages advance together; when the output word is held by
// the sink the whole pipeline holds, nothing is dropped or repeated. Segment lengths are
// to be written through the cfg port while no word is in flight; the block does not enforce it.
module arm_segment_forward_kinematics
    import afk_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = 13,
    parameter int LENGTH_BITS     = 12
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_idx,
    input  logic [LENGTH_BITS-1:0] cfg_data,
    afk_pose_if.sink               pose,
    afk_pos_if.source              pos
);

    localparam int PW  = LENGTH_BITS + 20;
    localparam int TOT = SC_LAT + KIN_LAT;

    typedef struct packed {
        logic signed [PW-1:0] h;
        logic signed [PW-1:0] x;
        logic signed [PW-1:0] y;
        logic signed [PW-1:0] z;
        logic signed [CW-1:0] cy;
        logic signed [CW-1:0] sy;
        logic signed [CW-1:0] cr;
        logic signed [CW-1:0] sr;
        logic signed [CW-1:0] cfp;
        logic signed [CW-1:0] sfp;
        logic signed [CW-1:0] cfy;
        logic signed [CW-1:0] sfy;
    } kin_t;

    logic [LENGTH_BITS-1:0] len_x_reg, len_y_reg, len_z_reg;
    logic                   en;
    logic [TOT-1:0]         vld_reg;
    logic signed [CW-1:0]   sp, cp, sy, cy, sr, cr, sfp, cfp, sfy, cfy;
    logic [LENGTH_BITS:0]   lxy;
    logic signed [LENGTH_BITS+1:0] lxy_s;
    logic signed [LENGTH_BITS:0]   lz_s;
    logic signed [LENGTH_BITS+CW+1:0] hp, zp;
    logic signed [LENGTH_BITS+CW:0]   lzc, lzs;
    kin_t                   st_reg [1:10];
    kin_t                   s1_next, st4_next, st7_next, st9_next;
    logic signed [PW-1:0]   ra1, ra2, rx1, rx2, ry1, ry2, rz1, rz2;
    logic signed [OUT_W-1:0] pos_x_reg, pos_y_reg, pos_z_reg;

    function automatic logic signed [OUT_W-1:0] finish(input logic signed [PW-1:0] v);
        logic signed [PW:0] r;
        logic signed [31:0] rr;
        r  = ((PW+1)'(v) + (PW+1)'(32768)) >>> 16;
        rr = 32'(r);
        if (rr > OUT_MAX)
            rr = OUT_MAX;
        else if (rr < -OUT_MAX)
            rr = -OUT_MAX;
        return OUT_W'(rr);
    endfunction

    assign en         = !vld_reg[TOT-1] || pos.ready;
    assign pose.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_x_reg <= '0;
            len_y_reg <= '0;
            len_z_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                REG_LEN_X: len_x_reg <= cfg_data;
                REG_LEN_Y: len_y_reg <= cfg_data;
                REG_LEN_Z: len_z_reg <= cfg_data;
                default:   ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[TOT-2:0], pose.valid};
    end

    afk_sincos #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_sc_lp
        (.clk(clk), .en(en), .angle(pose.local_pitch), .sin_q(sp), .cos_q(cp));
    afk_sincos #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_sc_ly
        (.clk(clk), .en(en), .angle(pose.local_yaw), .sin_q(sy), .cos_q(cy));
    afk_sincos #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_sc_fr
        (.clk(clk), .en(en), .angle(pose.frame_roll), .sin_q(sr), .cos_q(cr));
    afk_sincos #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_sc_fp
        (.clk(clk), .en(en), .angle(pose.frame_pitch), .sin_q(sfp), .cos_q(cfp));
    afk_sincos #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_sc_fy
        (.clk(clk), .en(en), .angle(pose.frame_yaw), .sin_q(sfy), .cos_q(cfy));

    // local vector terms
    assign lxy   = (LENGTH_BITS+1)'(len_x_reg) + (LENGTH_BITS+1)'(len_y_reg);
    assign lxy_s = signed'({1'b0, lxy});
    assign lz_s  = signed'({1'b0, len_z_reg});
    assign hp    = lxy_s * cp;
    assign zp    = lxy_s * sp;
    assign lzc   = lz_s * cy;
    assign lzs   = lz_s * sy;

    always_comb
    begin
        s1_next.h   = PW'(hp);
        s1_next.x   = PW'(lzc);
        s1_next.y   = PW'(lzs);
        s1_next.z   = PW'(zp);
        s1_next.cy  = cy;
        s1_next.sy  = sy;
        s1_next.cr  = cr;
        s1_next.sr  = sr;
        s1_next.cfp = cfp;
        s1_next.sfp = sfp;
        s1_next.cfy = cfy;
        s1_next.sfy = sfy;

        st4_next   = st_reg[3];
        st4_next.x = st_reg[3].x + ra1;
        st4_next.y = st_reg[3].y + ra2;

        st7_next   = st_reg[6];
        st7_next.y = rx1;

        st9_next   = st_reg[8];
        st9_next.z = ry2;
    end

    afk_rot #(.PW(PW)) u_rot_h
        (.clk(clk), .en(en), .a(st_reg[1].h), .b(PW'(0)), .c(st_reg[1].cy),
         .s(st_reg[1].sy), .o1(ra1), .o2(ra2));
    afk_rot #(.PW(PW)) u_rot_x
        (.clk(clk), .en(en), .a(st_reg[4].y), .b(st_reg[4].z), .c(st_reg[4].cr),
         .s(st_reg[4].sr), .o1(rx1), .o2(rx2));
    afk_rot #(.PW(PW)) u_rot_y
        (.clk(clk), .en(en), .a(st_reg[6].x), .b(rx2), .c(st_reg[6].cfp),
         .s(st_reg[6].sfp), .o1(ry1), .o2(ry2));
    afk_rot #(.PW(PW)) u_rot_z
        (.clk(clk), .en(en), .a(ry1), .b(st_reg[8].y), .c(st_reg[8].cfy),
         .s(st_reg[8].sfy), .o1(rz1), .o2(rz2));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg[1]  <= s1_next;
            st_reg[2]  <= st_reg[1];
            st_reg[3]  <= st_reg[2];
            st_reg[4]  <= st4_next;
            st_reg[5]  <= st_reg[4];
            st_reg[6]  <= st_reg[5];
            st_reg[7]  <= st7_next;
            st_reg[8]  <= st_reg[7];
            st_reg[9]  <= st9_next;
            st_reg[10] <= st_reg[9];
            pos_x_reg  <= finish(rz1);
            pos_y_reg  <= finish(rz2);
            pos_z_reg  <= finish(st_reg[10].z);
        end
    end

    assign pos.valid = vld_reg[TOT-1];
    assign pos.pos_x = pos_x_reg;
    assign pos.pos_y = pos_y_reg;
    assign pos.pos_z = pos_z_reg;

    a_out_sat: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[TOT-1] |-> (pos_x_reg <= OUT_MAX) && (pos_x_reg >= -OUT_MAX)
                        && (pos_y_reg <= OUT_MAX) && (pos_y_reg >= -OUT_MAX)
                        && (pos_z_reg <= OUT_MAX) && (pos_z_reg >= -OUT_MAX))
        else $error("position word outside saturation range");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_reg) && $stable(pos_x_reg) && $stable(pos_z_reg))
        else $error("pipeline moved during stall");

    a_zero_len: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[TOT-1] && len_x_reg == '0 && len_y_reg == '0 && len_z_reg == '0)
        |-> (pos_x_reg == '0) && (pos_y_reg == '0) && (pos_z_reg == '0))
        else $error("nonzero position with zero segment length");

endmodule
